[rtl/core/pdr_pkg.sv]
// package for the parabolic dac ramp: payload types, state type, phase codes
package pdr_pkg;

   localparam int DAC_BITS = 16;
   localparam int STEP_BITS = 17;
   localparam logic [15:0] DAC_MASK = 16'((17'd1 << DAC_BITS) - 17'd1);
   localparam logic [STEP_BITS-1:0] STEP_MAX = {STEP_BITS{1'b1}};

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_ACCEL = 3'd1;
   localparam logic [2:0] PH_HALF = 3'd2;
   localparam logic [2:0] PH_DECEL = 3'd3;
   localparam logic [2:0] PH_FINAL = 3'd4;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_START = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [4:0]  channel;
      logic [15:0] start_value;
      logic [15:0] target;
      logic [15:0] accel;
      logic        mode;
   } pdr_req_type;

   typedef struct packed {
      logic [4:0]  out_channel;
      logic [15:0] dac_value;
      logic        busy_res;
      logic        last;
   } pdr_rsp_type;

   typedef struct packed {
      logic [15:0]          position;
      logic [STEP_BITS-1:0] step_size;
      logic [15:0]          goal;
      logic [15:0]          midpoint;
      logic                 rising;
      logic [2:0]           phase;
      logic                 ramp_mode;
      logic [15:0]          increment;
      logic [4:0]           held_channel;
   } pdr_state_type;

endpackage

[rtl/core/pdr_step.sv]
// next ramp state and dac sample for one request
module pdr_step
   import pdr_pkg::*;
(
   input  pdr_req_type   req,
   input  pdr_state_type cur,
   output pdr_state_type nxt,
   output pdr_rsp_type   rsp
);

   always_comb begin
      pdr_state_type        s;
      logic [16:0]          mid_sum;
      logic [17:0]          grow;
      logic [STEP_BITS-1:0] inc_w;
      logic [STEP_BITS-1:0] diff;
      logic [STEP_BITS-1:0] a_step;
      logic [15:0]          a_lim;
      logic [17:0]          p_up;
      logic [17:0]          l_up;
      logic                 a_ok;
      logic [15:0]          a_pos;
      logic [15:0]          st;
      logic [15:0]          tg;

      s = cur;
      st = req.start_value & DAC_MASK;
      tg = req.target & DAC_MASK;
      mid_sum = {1'b0, st} + {1'b0, tg};
      if (req.operation == OP_START) begin
         s.held_channel = req.channel;
         s.position = st;
         s.goal = tg;
         s.increment = (req.accel == 16'd0) ? 16'd1 : req.accel;
         s.ramp_mode = req.mode;
         s.rising = (st < tg);
         s.midpoint = mid_sum[16:1];
         s.step_size = {1'b0, s.increment};
         s.phase = PH_ACCEL;
      end

      inc_w = {1'b0, s.increment};
      grow = {1'b0, s.step_size} + {2'b00, s.increment};
      diff = s.step_size - inc_w;

      a_step = s.step_size;
      a_lim = s.goal;
      if (s.phase == PH_ACCEL) begin
         a_step = grow[17] ? STEP_MAX : grow[16:0];
         a_lim = s.ramp_mode ? s.midpoint : s.goal;
      end else begin
         a_step = ((s.step_size > inc_w) && (diff > inc_w)) ? diff : inc_w;
      end

      p_up = {2'b00, s.position} + {1'b0, a_step};
      l_up = {2'b00, a_lim} + {1'b0, a_step};
      if (s.rising) begin
         a_ok = (p_up <= {2'b00, a_lim});
         a_pos = p_up[15:0];
      end else begin
         a_ok = ({2'b00, s.position} >= l_up);
         a_pos = s.position - a_step[15:0];
      end

      nxt = s;
      rsp.out_channel = s.held_channel;
      rsp.dac_value = s.position;
      rsp.busy_res = 1'b1;
      rsp.last = 1'b0;
      unique case (s.phase)
         PH_ACCEL: begin
            nxt.step_size = a_step;
            if (a_ok) begin
               nxt.position = a_pos;
            end else begin
               nxt.phase = s.ramp_mode ? PH_HALF : PH_FINAL;
            end
         end
         PH_HALF: begin
            rsp.dac_value = s.midpoint;
            nxt.position = s.midpoint;
            nxt.phase = PH_DECEL;
         end
         PH_DECEL: begin
            nxt.step_size = a_step;
            if (a_ok) begin
               nxt.position = a_pos;
            end else begin
               nxt.phase = PH_FINAL;
            end
         end
         PH_FINAL: begin
            rsp.dac_value = s.goal;
            rsp.last = 1'b1;
            nxt.position = s.goal;
            nxt.phase = PH_IDLE;
         end
         default: begin
            nxt.phase = PH_IDLE;
            rsp.busy_res = 1'b0;
         end
      endcase
   end

endmodule

[rtl/core/parabolic_dac_ramp.sv]
// top level of the constant acceleration dac ramp generator
//
// requests come in on req_ (valid/ready); each request gives exactly one
// response on rsp_. a request with operation start loads channel, start
// value, target, acceleration and mode and answers with the start value;
// a tick request answers with the next sample of the ramp, or with the
// held position and busy_res low when no ramp runs.
// latency: the response is valid the cycle after the request is taken.
// throughput: one request per cycle while the receiver takes each response;
// the ramp state and the response register are updated together in the cycle a request is taken.
// the response register parts the two sides: a new request is taken while the
// register is empty or when the held response is taken in the same cycle.
// when the receiver stalls, rsp_valid and rsp_data hold and req_ready
// drops until the held response is taken.
// synchronous reset clears the ramp state to idle at position zero and
// empties the response register.
module parabolic_dac_ramp
   import pdr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  pdr_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output pdr_rsp_type rsp_data
);

   pdr_state_type state_ff;
   pdr_state_type state_in;
   pdr_rsp_type   rsp_data_ff;
   pdr_rsp_type   rsp_data_in;
   logic          rsp_valid_ff;
   logic          req_fire;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire = req_valid && req_ready;

   pdr_step u_step (
      .req (req_data),
      .cur (state_ff),
      .nxt (state_in),
      .rsp (rsp_data_in)
   );

   // all-zero state is idle at position zero
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         state_ff <= state_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

`ifndef SYNTHESIS
   a_step_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase != PH_IDLE |-> state_ff.step_size != '0)
      else $error("step size zero during a ramp");

   a_start_sample: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.operation == OP_START |=>
         rsp_valid && rsp_data.busy_res && !rsp_data.last &&
         rsp_data.dac_value == ($past(req_data.start_value) & DAC_MASK))
      else $error("start request did not answer with start value");

   a_final_goal: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.operation == OP_TICK && state_ff.phase == PH_FINAL |=>
         rsp_data.last && rsp_data.dac_value == $past(state_ff.goal) &&
         state_ff.phase == PH_IDLE && state_ff.position == $past(state_ff.goal))
      else $error("final sample not on target");

   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.operation == OP_TICK && state_ff.phase == PH_IDLE |=>
         !rsp_data.busy_res && !rsp_data.last && $stable(state_ff))
      else $error("idle tick changed state");
`endif

endmodule
